// ===== src/lsp2p_pkg.sv =====
package lsp2p_pkg;

  localparam int unsigned RANGE_BITS_DEF = 16;
  localparam int unsigned ANGLE_BITS_DEF = 16;

  // cordic datapath: x, y in Q2.30 with headroom, z in 2^-32 turn units
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CORDIC_W     = 34;
  localparam int unsigned TURN_W       = 32;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

  localparam logic [TURN_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  localparam int unsigned Q14_W    = 16;
  localparam int unsigned Q_RAW_W  = CORDIC_W - 16;
  localparam int unsigned PPM_W    = 8;
  localparam int unsigned CP_W     = 24;
  localparam int unsigned CENTRE_W = 16;
  localparam int unsigned PIXEL_W  = 15;

  localparam logic [PPM_W-1:0] PPM_RST       = 8'd40;
  localparam int unsigned      MAX_RANGE_RST = 4096;

  // configuration port
  localparam int unsigned APB_AW  = 5;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_MIN_RANGE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_RANGE   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_ANGLE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ANGLE_STEP  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PPM         = 3'd4;

  typedef struct packed {
    logic                       run;
    logic                       flip;
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
  } cordic_t;

  // round Q2.30 to Q1.14 with a floor shift and clamp to plus or minus one
  function automatic logic signed [Q14_W-1:0] to_q14(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] t;
    logic signed [CORDIC_W-1:0] sh;
    logic signed [Q_RAW_W-1:0]  r;
    logic signed [Q14_W-1:0]    res;
    t   = v + (CORDIC_W'(1) <<< 15);
    sh  = t >>> 16;
    r   = sh[Q_RAW_W-1:0];
    res = r[Q14_W-1:0];
    if (r > Q_RAW_W'(16384)) begin
      res = Q14_W'(16384);
    end else if (r < -Q_RAW_W'(16384)) begin
      res = -Q14_W'(16384);
    end
    return res;
  endfunction

endpackage

// ===== src/lsp2p_sample_if.sv =====
interface lsp2p_sample_if #(
  parameter int unsigned RANGE_BITS = lsp2p_pkg::RANGE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [RANGE_BITS-1:0] range_sample;
  logic                  first_of_scan;

  modport source (output valid, range_sample, first_of_scan, input ready);
  modport sink   (input valid, range_sample, first_of_scan, output ready);
endinterface

// ===== src/lsp2p_pixel_if.sv =====
interface lsp2p_pixel_if ();
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [lsp2p_pkg::PIXEL_W-1:0] pixel_x;
  logic [lsp2p_pkg::PIXEL_W-1:0] pixel_y;

  modport source (output valid, hit, pixel_x, pixel_y, input ready);
  modport sink   (input valid, hit, pixel_x, pixel_y, output ready);
endinterface

// ===== src/laser_scan_polar_to_pixel.sv =====
// channel    dir  modport  payload
// sample_i   in   sink     range_sample, first_of_scan
// pixel_o    out  source   hit, pixel_x, pixel_y
// apb        in   slave    psel/penable/pwrite/paddr/pwdata -> prdata, pready
//
// one transaction at a time: the result passes the head register, sixteen cordic
// cells, four scaling stages, the result buffer and the output register; ready
// rises as the result enters the output register, so a new sample waits for an empty buffer.
// a stalled output register keeps its transaction while the next sample runs; a second
// finished result then waits in the buffer and holds sample_i.ready low
// rst_ni is asynchronous and clears all control state; configuration resets

module laser_scan_polar_to_pixel #(
  parameter int unsigned RANGE_BITS = lsp2p_pkg::RANGE_BITS_DEF,
  parameter int unsigned ANGLE_BITS = lsp2p_pkg::ANGLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lsp2p_sample_if.sink                 sample_i,
  lsp2p_pixel_if.source                pixel_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsp2p_pkg::APB_AW-1:0] paddr,
  input  logic [lsp2p_pkg::APB_DW-1:0] pwdata,
  output logic [lsp2p_pkg::APB_DW-1:0] prdata,
  output logic                         pready
);
  import lsp2p_pkg::*;

  localparam int unsigned RANGE_FRAC = RANGE_BITS - 6;
  localparam int unsigned PAD_W      = TURN_W - ANGLE_BITS;
  localparam logic [RANGE_BITS:0] TENTH =
    (RANGE_BITS + 1)'(((1 << RANGE_FRAC) + 5) / 10);
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic [RANGE_BITS-1:0] min_range, max_range;
  logic [ANGLE_BITS-1:0] start_angle, angle_step;
  logic [PPM_W-1:0]      ppm;

  logic                      accept;
  logic [ANGLE_BITS-1:0]     beam_d, beam_q;
  logic [TURN_W-1:0]         turn;
  logic                      flip;
  logic [TURN_W-1:0]         turn_fold;
  logic                      hit_d;
  logic [RANGE_BITS+PPM_W-1:0] span;
  logic signed [CENTRE_W-1:0]  centre_d, centre_q;
  logic [RANGE_BITS-1:0]     range_q;
  logic                      hit_q;
  logic                      busy_q;
  logic                      head_run_q;
  logic                      head_flip_q;
  logic signed [CORDIC_W-1:0] head_z_q;
  cordic_t                   chain [CORDIC_STEPS+1];

  logic               map_done;
  logic [PIXEL_W-1:0] map_x, map_y;

  logic               res_valid_q;
  logic               res_hit_q;
  logic [PIXEL_W-1:0] res_x_q, res_y_q;
  logic               out_valid_q;
  logic               out_hit_q;
  logic [PIXEL_W-1:0] out_x_q, out_y_q;
  logic               move;

  lsp2p_apb_regs #(
    .RANGE_BITS (RANGE_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .min_range_o   (min_range),
    .max_range_o   (max_range),
    .start_angle_o (start_angle),
    .angle_step_o  (angle_step),
    .ppm_o         (ppm)
  );

  assign sample_i.ready = !busy_q && !res_valid_q;
  assign accept         = sample_i.valid && sample_i.ready;

  assign beam_d = sample_i.first_of_scan ? start_angle + QUARTER : beam_q + angle_step;

  // fold the second and third quadrants by half a turn, negate results later
  assign turn      = {beam_d, {PAD_W{1'b0}}};
  assign flip      = turn[TURN_W-1] ^ turn[TURN_W-2];
  assign turn_fold = {turn[TURN_W-1] ^ flip, turn[TURN_W-2:0]};

  assign hit_d = (sample_i.range_sample > min_range) &&
                 (({1'b0, sample_i.range_sample} + TENTH) < {1'b0, max_range});

  assign span     = max_range * ppm;
  assign centre_d = signed'(CENTRE_W'(span >> RANGE_FRAC)) - CENTRE_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_q      <= '0;
      busy_q      <= 1'b0;
      head_run_q  <= 1'b0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_run_q <= accept;
      if (accept) begin
        beam_q <= beam_d;
        busy_q <= 1'b1;
      end else if (map_done) begin
        busy_q <= 1'b0;
      end
      if (map_done) begin
        res_valid_q <= 1'b1;
      end else if (move) begin
        res_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (pixel_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      range_q     <= sample_i.range_sample;
      hit_q       <= hit_d;
      centre_q    <= centre_d;
      head_flip_q <= flip;
      head_z_q    <= CORDIC_W'(signed'(turn_fold));
    end
    if (map_done) begin
      res_hit_q <= hit_q;
      res_x_q   <= hit_q ? map_x : '0;
      res_y_q   <= hit_q ? map_y : '0;
    end
    if (move) begin
      out_hit_q <= res_hit_q;
      out_x_q   <= res_x_q;
      out_y_q   <= res_y_q;
    end
  end

  // every rotation starts from the gain-compensated unit vector
  assign chain[0] = '{run: head_run_q, flip: head_flip_q, x: CORDIC_GAIN, y: '0,
                      z: head_z_q};

  for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cell
    lsp2p_cordic_cell #(
      .SHIFT (gi)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[gi]),
      .cell_o (chain[gi+1])
    );
  end

  lsp2p_pixel_map #(
    .RANGE_BITS (RANGE_BITS)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rot_i     (chain[CORDIC_STEPS]),
    .range_i   (range_q),
    .ppm_i     (ppm),
    .centre_i  (centre_q),
    .done_o    (map_done),
    .pixel_x_o (map_x),
    .pixel_y_o (map_y)
  );

  assign move = res_valid_q && (!out_valid_q || pixel_o.ready);

  assign pixel_o.valid   = out_valid_q;
  assign pixel_o.hit     = out_hit_q;
  assign pixel_o.pixel_x = out_x_q;
  assign pixel_o.pixel_y = out_y_q;

endmodule

// ===== src/lsp2p_apb_regs.sv =====
module lsp2p_apb_regs #(
  parameter int unsigned RANGE_BITS = lsp2p_pkg::RANGE_BITS_DEF,
  parameter int unsigned ANGLE_BITS = lsp2p_pkg::ANGLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lsp2p_pkg::APB_AW-1:0]  paddr,
  input  logic [lsp2p_pkg::APB_DW-1:0]  pwdata,
  output logic [lsp2p_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  output logic [RANGE_BITS-1:0]         min_range_o,
  output logic [RANGE_BITS-1:0]         max_range_o,
  output logic [ANGLE_BITS-1:0]         start_angle_o,
  output logic [ANGLE_BITS-1:0]         angle_step_o,
  output logic [lsp2p_pkg::PPM_W-1:0]   ppm_o
);
  import lsp2p_pkg::*;

  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  wr_en;
  logic [RANGE_BITS-1:0] min_range_q, max_range_q;
  logic [ANGLE_BITS-1:0] start_angle_q, angle_step_q;
  logic [PPM_W-1:0]      ppm_q;

  assign reg_idx = paddr[APB_AW-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q   <= '0;
      max_range_q   <= RANGE_BITS'(MAX_RANGE_RST);
      start_angle_q <= '0;
      angle_step_q  <= '0;
      ppm_q         <= PPM_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MIN_RANGE:   min_range_q   <= pwdata[RANGE_BITS-1:0];
        REG_MAX_RANGE:   max_range_q   <= pwdata[RANGE_BITS-1:0];
        REG_START_ANGLE: start_angle_q <= pwdata[ANGLE_BITS-1:0];
        REG_ANGLE_STEP:  angle_step_q  <= pwdata[ANGLE_BITS-1:0];
        REG_PPM:         ppm_q         <= pwdata[PPM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_MIN_RANGE:   prdata = APB_DW'(min_range_q);
      REG_MAX_RANGE:   prdata = APB_DW'(max_range_q);
      REG_START_ANGLE: prdata = APB_DW'(start_angle_q);
      REG_ANGLE_STEP:  prdata = APB_DW'(angle_step_q);
      REG_PPM:         prdata = APB_DW'(ppm_q);
      default:         prdata = '0;
    endcase
  end

  assign min_range_o   = min_range_q;
  assign max_range_o   = max_range_q;
  assign start_angle_o = start_angle_q;
  assign angle_step_o  = angle_step_q;
  assign ppm_o         = ppm_q;

endmodule

// ===== src/lsp2p_cordic_cell.sv =====
module lsp2p_cordic_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lsp2p_pkg::cordic_t cell_i,
  output lsp2p_pkg::cordic_t cell_o
);
  import lsp2p_pkg::*;

  localparam logic signed [CORDIC_W-1:0] ATAN =
    {{(CORDIC_W-TURN_W){1'b0}}, ATAN_TURNS[SHIFT]};

  logic signed [CORDIC_W-1:0] dx, dy;
  logic                       run_q;
  logic                       flip_q;
  logic signed [CORDIC_W-1:0] x_q, y_q, z_q;

  assign dx = cell_i.y >>> SHIFT;
  assign dy = cell_i.x >>> SHIFT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= cell_i.run;
    end
  end

  // rotate towards z = 0
  always_ff @(posedge clk_i) begin
    flip_q <= cell_i.flip;
    if (!cell_i.z[CORDIC_W-1]) begin
      x_q <= cell_i.x - dx;
      y_q <= cell_i.y + dy;
      z_q <= cell_i.z - ATAN;
    end else begin
      x_q <= cell_i.x + dx;
      y_q <= cell_i.y - dy;
      z_q <= cell_i.z + ATAN;
    end
  end

  assign cell_o = '{run: run_q, flip: flip_q, x: x_q, y: y_q, z: z_q};

endmodule

// ===== src/lsp2p_pixel_map.sv =====
module lsp2p_pixel_map #(
  parameter int unsigned RANGE_BITS = lsp2p_pkg::RANGE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lsp2p_pkg::cordic_t                    rot_i,
  input  logic [RANGE_BITS-1:0]                 range_i,
  input  logic [lsp2p_pkg::PPM_W-1:0]           ppm_i,
  input  logic signed [lsp2p_pkg::CENTRE_W-1:0] centre_i,
  output logic                                  done_o,
  output logic [lsp2p_pkg::PIXEL_W-1:0]         pixel_x_o,
  output logic [lsp2p_pkg::PIXEL_W-1:0]         pixel_y_o
);
  import lsp2p_pkg::*;

  localparam int unsigned PROD_W = Q14_W + PPM_W + 1;
  localparam int unsigned RC_W   = RANGE_BITS + 1 + CP_W;
  localparam int unsigned SHR    = RANGE_BITS - 6 + 14;
  localparam int unsigned SUM_W  = CENTRE_W + 1;

  logic [2:0] run_q;

  logic signed [Q14_W-1:0]  cq, sq;
  logic signed [Q14_W-1:0]  cos_q, nsin_q;
  logic signed [PROD_W-1:0] cp_c, sp_c;
  logic signed [CP_W-1:0]   cp_q, sp_q;
  logic signed [RC_W-1:0]   rc_c, rs_c;
  logic signed [RC_W-1:0]   rc_q, rs_q;
  logic signed [RC_W-1:0]   rc_sh, rs_sh;
  logic signed [SUM_W-1:0]  sum_x, sum_y;
  logic                     done_q;
  logic [PIXEL_W-1:0]       px_q, py_q;

  function automatic logic [PIXEL_W-1:0] clamp_px(input logic signed [SUM_W-1:0] v);
    logic [PIXEL_W-1:0] res;
    res = v[PIXEL_W-1:0];
    if (v[SUM_W-1]) begin
      res = '0;
    end else if (v[SUM_W-2:PIXEL_W] != '0) begin
      res = '1;
    end
    return res;
  endfunction

  assign cq = to_q14(rot_i.x);
  assign sq = to_q14(rot_i.y);

  assign cp_c = cos_q * signed'({1'b0, ppm_i});
  assign sp_c = nsin_q * signed'({1'b0, ppm_i});

  assign rc_c = signed'({1'b0, range_i}) * cp_q;
  assign rs_c = signed'({1'b0, range_i}) * sp_q;

  // c + floor(t / 2^k) equals floor((c * 2^k + t) / 2^k)
  assign rc_sh = rc_q >>> SHR;
  assign rs_sh = rs_q >>> SHR;
  assign sum_x = SUM_W'(centre_i) + SUM_W'(signed'(rc_sh[CENTRE_W-1:0]));
  assign sum_y = SUM_W'(centre_i) + SUM_W'(signed'(rs_sh[CENTRE_W-1:0]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      done_q <= 1'b0;
    end else begin
      run_q  <= {run_q[1:0], rot_i.run};
      done_q <= run_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    // y axis is flipped, so the sine term enters negated
    cos_q  <= rot_i.flip ? -cq : cq;
    nsin_q <= rot_i.flip ? sq : -sq;
    cp_q   <= cp_c[CP_W-1:0];
    sp_q   <= sp_c[CP_W-1:0];
    rc_q   <= rc_c;
    rs_q   <= rs_c;
    px_q   <= clamp_px(sum_x);
    py_q   <= clamp_px(sum_y);
  end

  assign done_o    = done_q;
  assign pixel_x_o = px_q;
  assign pixel_y_o = py_q;

endmodule
